### rtl/core/page_replacement_fifo_lru_top_defines.svh
// assertion macros for the page replacement block
// used by page_replacement_fifo_lru_top; expects clk_i and rst_ni in scope
`ifndef PAGE_REPLACEMENT_FIFO_LRU_TOP_DEFINES_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PRF_ASSERT_NOW(lbl, ante, cons, msg)
`define PRF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/core/prf_pkg.sv
// shared types, constants and helpers for the page replacement block
// no dependencies; used by the channel interfaces, the top module and the bench
package prf_pkg;

  // sizing
  localparam int FRAMES    = 4;
  localparam int PAGE_BITS = 8;
  localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = FRAME_W;
  localparam int CNT_W     = $clog2(FRAMES + 1);

  // word field widths
  localparam int OPERATION_W   = 1;
  localparam int PAGE_FIELD_W  = 8;
  localparam int FRAME_FIELD_W = 2;
  localparam int COUNT_W       = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // config port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_POLICY = '0;

  typedef enum logic [OPERATION_W-1:0] {
    OP_ACCESS = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_e;

  // one frame entry in the frame ram
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [RANK_W-1:0]    rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // word page field to stored page (low bits, zero extended)
  function automatic logic [PAGE_BITS-1:0] page_from_field(
    input logic [PAGE_FIELD_W-1:0] f
  );
    logic [PAGE_BITS+PAGE_FIELD_W-1:0] w;
    w = {{PAGE_BITS{1'b0}}, f};
    return w[PAGE_BITS-1:0];
  endfunction

  // stored page to word page field
  function automatic logic [PAGE_FIELD_W-1:0] page_to_field(
    input logic [PAGE_BITS-1:0] p
  );
    logic [PAGE_BITS+PAGE_FIELD_W-1:0] w;
    w = {{PAGE_FIELD_W{1'b0}}, p};
    return w[PAGE_FIELD_W-1:0];
  endfunction

  // frame number to word frame field, modulo the field size
  function automatic logic [FRAME_FIELD_W-1:0] frame_to_field(
    input logic [FRAME_W-1:0] f
  );
    logic [FRAME_W+FRAME_FIELD_W-1:0] w;
    w = {{FRAME_FIELD_W{1'b0}}, f};
    return w[FRAME_FIELD_W-1:0];
  endfunction

endpackage

### rtl/core/prf_if.sv
// valid/ready channel interfaces for access words and result words
// depends on prf_pkg
interface prf_in_if;
  import prf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OPERATION_W-1:0]  operation;
  logic [PAGE_FIELD_W-1:0] page;

  modport source (output valid, output operation, output page, input ready);
  modport sink   (input valid, input operation, input page, output ready);
endinterface

interface prf_out_if;
  import prf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [FRAME_FIELD_W-1:0] frame_index;
  logic                     evicted_valid;
  logic [PAGE_FIELD_W-1:0]  evicted_page;
  logic [COUNT_W-1:0]       hit_count;
  logic [COUNT_W-1:0]       fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output hit_count, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input hit_count, input fault_count, output ready);
endinterface

### rtl/core/page_replacement_fifo_lru_top.sv
// page replacement block top: fifo or lru replacement over a small frame set
// depends on prf_pkg, prf_if, prf_ram and page_replacement_fifo_lru_top_defines.svh
// an access is accepted in idle, runs the scan pass, the decide step and the rank update
// pass, then waits in done for the output register; a clear goes straight to done; one word
// at a time, each pass one frame per cycle through the single read port of the frame ram
// reset: async, clears valid bits, pointer, counts, policy and control; ram is not swept
`include "page_replacement_fifo_lru_top_defines.svh"

module page_replacement_fifo_lru_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [prf_pkg::PADDR_W-1:0]      paddr,
  input  logic [prf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [prf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  prf_in_if.sink                           in_i,
  prf_out_if.source                        out_o
);
  import prf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  // control
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic [FRAME_W-1:0]   chk_q, chk_d;
  logic [FRAMES-1:0]    frame_valid_q, frame_valid_d;
  logic [FRAME_W-1:0]   fifo_ptr_q, fifo_ptr_d;
  logic [COUNT_W-1:0]   hits_q, hits_d;
  logic [COUNT_W-1:0]   faults_q, faults_d;
  policy_e              policy_q;
  logic                 out_valid_q, out_valid_d;

  // per-access datapath
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 found_q, found_d;
  logic [FRAME_W-1:0]   hit_idx_q, hit_idx_d;
  logic [RANK_W-1:0]    hit_rank_q, hit_rank_d;
  logic                 empty_found_q, empty_found_d;
  logic [FRAME_W-1:0]   empty_idx_q, empty_idx_d;
  logic [FRAME_W-1:0]   max_idx_q, max_idx_d;
  logic [RANK_W-1:0]    max_rank_q, max_rank_d;
  logic [RANK_W-1:0]    ptr_rank_q, ptr_rank_d;
  logic [FRAME_W-1:0]   target_q, target_d;
  logic                 was_valid_q, was_valid_d;
  logic [RANK_W-1:0]    old_rank_q, old_rank_d;
  logic [PAGE_BITS-1:0] ev_page_q, ev_page_d;

  // output word register
  logic                     out_hit_q, out_hit_d;
  logic [FRAME_FIELD_W-1:0] out_frame_q, out_frame_d;
  logic                     out_ev_valid_q, out_ev_valid_d;
  logic [PAGE_FIELD_W-1:0]  out_ev_page_q, out_ev_page_d;
  logic [COUNT_W-1:0]       out_hits_q, out_hits_d;
  logic [COUNT_W-1:0]       out_faults_q, out_faults_d;

  // decision
  logic [FRAME_W-1:0]   dec_target;
  logic                 dec_was_valid;
  logic [RANK_W-1:0]    dec_old_rank;
  logic [FRAME_W-1:0]   ptr_next;

  // frame ram
  logic                 ram_we, ram_re;
  logic [FRAME_W-1:0]   ram_waddr, ram_raddr;
  entry_t               ram_wdata, rd_entry;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic                 cur_valid;
  logic                 pass_last;
  logic                 rd_more;
  logic [RANK_W-1:0]    aged_rank;
  logic [REG_IDX_W-1:0] reg_idx;

  prf_ram #(
    .Width (ENTRY_W),
    .Depth (FRAMES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign cur_valid = frame_valid_q[chk_q];
  assign pass_last = (chk_q == FRAME_W'(FRAMES - 1));
  assign rd_more   = (rd_cnt_q < CNT_W'(FRAMES));

  // config register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_POLICY) begin
      prdata[0] = policy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_FIFO;
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_POLICY)) begin
      policy_q <= policy_e'(pwdata[0]);
    end
  end

  // fifo pointer advance modulo frame count
  assign ptr_next = (fifo_ptr_q == FRAME_W'(FRAMES - 1)) ? '0 : fifo_ptr_q + 1'b1;

  // victim choice once the scan is complete
  always_comb begin
    dec_target    = max_idx_q;
    dec_was_valid = 1'b1;
    dec_old_rank  = max_rank_q;
    priority if (found_q) begin
      dec_target    = hit_idx_q;
      dec_was_valid = 1'b1;
      dec_old_rank  = hit_rank_q;
    end else if (policy_q == POLICY_FIFO) begin
      dec_target    = fifo_ptr_q;
      dec_was_valid = frame_valid_q[fifo_ptr_q];
      dec_old_rank  = ptr_rank_q;
    end else if (empty_found_q) begin
      dec_target    = empty_idx_q;
      dec_was_valid = 1'b0;
      dec_old_rank  = '0;
    end else begin
      dec_target    = max_idx_q;
      dec_was_valid = 1'b1;
      dec_old_rank  = max_rank_q;
    end
  end

  // age a valid non-target frame that is younger than the touched one, or any if it was empty
  assign aged_rank = (cur_valid && (!was_valid_q || (rd_entry.rank < old_rank_q)))
                     ? rd_entry.rank + 1'b1 : rd_entry.rank;

  // sequencer and read-modify-write of the frame ram
  always_comb begin
    state_d        = state_q;
    rd_cnt_d       = rd_cnt_q;
    chk_d          = chk_q;
    frame_valid_d  = frame_valid_q;
    fifo_ptr_d     = fifo_ptr_q;
    hits_d         = hits_q;
    faults_d       = faults_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    page_d         = page_q;
    found_d        = found_q;
    hit_idx_d      = hit_idx_q;
    hit_rank_d     = hit_rank_q;
    empty_found_d  = empty_found_q;
    empty_idx_d    = empty_idx_q;
    max_idx_d      = max_idx_q;
    max_rank_d     = max_rank_q;
    ptr_rank_d     = ptr_rank_q;
    target_d       = target_q;
    was_valid_d    = was_valid_q;
    old_rank_d     = old_rank_q;
    ev_page_d      = ev_page_q;
    out_hit_d      = out_hit_q;
    out_frame_d    = out_frame_q;
    out_ev_valid_d = out_ev_valid_q;
    out_ev_page_d  = out_ev_page_q;
    out_hits_d     = out_hits_q;
    out_faults_d   = out_faults_q;
    ram_re         = 1'b0;
    ram_raddr      = rd_cnt_q[FRAME_W-1:0];
    ram_we         = 1'b0;
    ram_waddr      = chk_q;
    ram_wdata      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          page_d = page_from_field(in_i.page);
          if (in_i.operation == OP_CLEAR) begin
            frame_valid_d = '0;
            fifo_ptr_d    = '0;
            hits_d        = '0;
            faults_d      = '0;
            found_d       = 1'b0;
            target_d      = '0;
            was_valid_d   = 1'b0;
            ev_page_d     = '0;
            state_d       = ST_DONE;
          end else begin
            ram_re        = 1'b1;
            ram_raddr     = '0;
            rd_cnt_d      = CNT_W'(1);
            chk_d         = '0;
            found_d       = 1'b0;
            empty_found_d = 1'b0;
            max_idx_d     = '0;
            max_rank_d    = '0;
            state_d       = ST_SCAN;
          end
        end
      end

      // one frame per cycle: match, first empty, oldest rank
      ST_SCAN: begin
        if (rd_more) begin
          ram_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (cur_valid && (rd_entry.page == page_q) && !found_q) begin
          found_d    = 1'b1;
          hit_idx_d  = chk_q;
          hit_rank_d = rd_entry.rank;
        end
        if (!cur_valid && !empty_found_q) begin
          empty_found_d = 1'b1;
          empty_idx_d   = chk_q;
        end
        if (cur_valid && (rd_entry.rank > max_rank_q)) begin
          max_idx_d  = chk_q;
          max_rank_d = rd_entry.rank;
        end
        if (chk_q == fifo_ptr_q) begin
          ptr_rank_d = rd_entry.rank;
        end
        chk_d = chk_q + 1'b1;
        if (pass_last) begin
          state_d = ST_DECIDE;
        end
      end

      // latch the victim, bump counts, start the update pass
      ST_DECIDE: begin
        target_d    = dec_target;
        was_valid_d = dec_was_valid;
        old_rank_d  = dec_old_rank;
        ev_page_d   = '0;
        if (found_q) begin
          if (hits_q != COUNT_MAX) begin
            hits_d = hits_q + 1'b1;
          end
        end else begin
          if (faults_q != COUNT_MAX) begin
            faults_d = faults_q + 1'b1;
          end
          if (policy_q == POLICY_FIFO) begin
            fifo_ptr_d = ptr_next;
          end
        end
        ram_re    = 1'b1;
        ram_raddr = '0;
        rd_cnt_d  = CNT_W'(1);
        chk_d     = '0;
        state_d   = ST_UPDATE;
      end

      // write back each frame: target gets the page, younger frames age
      ST_UPDATE: begin
        if (rd_more) begin
          ram_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        ram_we = 1'b1;
        if (chk_q == target_q) begin
          ram_wdata.page          = page_q;
          ram_wdata.rank          = '0;
          frame_valid_d[target_q] = 1'b1;
          if (was_valid_q && !found_q) begin
            ev_page_d = rd_entry.page;
          end
        end else begin
          ram_wdata.page = rd_entry.page;
          ram_wdata.rank = aged_rank;
        end
        chk_d = chk_q + 1'b1;
        if (pass_last) begin
          state_d = ST_DONE;
        end
      end

      // hand the word to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d    = 1'b1;
          out_hit_d      = found_q;
          out_frame_d    = frame_to_field(target_q);
          out_ev_valid_d = !found_q && was_valid_q;
          out_ev_page_d  = page_to_field(ev_page_q);
          out_hits_d     = hits_q;
          out_faults_d   = faults_q;
          state_d        = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rd_cnt_q      <= '0;
      chk_q         <= '0;
      frame_valid_q <= '0;
      fifo_ptr_q    <= '0;
      hits_q        <= '0;
      faults_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rd_cnt_q      <= rd_cnt_d;
      chk_q         <= chk_d;
      frame_valid_q <= frame_valid_d;
      fifo_ptr_q    <= fifo_ptr_d;
      hits_q        <= hits_d;
      faults_q      <= faults_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    page_q         <= page_d;
    found_q        <= found_d;
    hit_idx_q      <= hit_idx_d;
    hit_rank_q     <= hit_rank_d;
    empty_found_q  <= empty_found_d;
    empty_idx_q    <= empty_idx_d;
    max_idx_q      <= max_idx_d;
    max_rank_q     <= max_rank_d;
    ptr_rank_q     <= ptr_rank_d;
    target_q       <= target_d;
    was_valid_q    <= was_valid_d;
    old_rank_q     <= old_rank_d;
    ev_page_q      <= ev_page_d;
    out_hit_q      <= out_hit_d;
    out_frame_q    <= out_frame_d;
    out_ev_valid_q <= out_ev_valid_d;
    out_ev_page_q  <= out_ev_page_d;
    out_hits_q     <= out_hits_d;
    out_faults_q   <= out_faults_d;
  end

  // channel ports
  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = out_hit_q;
  assign out_o.frame_index   = out_frame_q;
  assign out_o.evicted_valid = out_ev_valid_q;
  assign out_o.evicted_page  = out_ev_page_q;
  assign out_o.hit_count     = out_hits_q;
  assign out_o.fault_count   = out_faults_q;

  // checks
  `PRF_ASSERT_NOW(a_ram_no_collide, ram_we && ram_re, ram_waddr != ram_raddr, "frame ram read and write hit the same entry")
  `PRF_ASSERT_NOW(a_hit_no_evict, out_valid_q, !(out_hit_q && out_ev_valid_q), "hit word reports an eviction")
  `PRF_ASSERT_NEXT(a_target_valid, (state_q == ST_UPDATE) && pass_last, frame_valid_q[target_q], "target frame not valid after update pass")

endmodule

### rtl/core/prf_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module prf_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### bench/tb_top.sv
// self-checking testbench for page_replacement_fifo_lru_top: fifo and lru page frames
// depends on prf_pkg and the prf_in_if / prf_out_if channel interfaces from the rtl
`timescale 1ns / 1ps

module tb_top;
  import prf_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int SETTLE      = 2 * FRAMES + 5;
  localparam int RAND_PHASES = 6;
  localparam int RAND_WORDS  = 325;
  localparam int PRINT_CAP   = 40;

  // one result word, field by field
  typedef struct packed {
    logic                     hit;
    logic [FRAME_FIELD_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_FIELD_W-1:0]  evicted_page;
    logic [COUNT_W-1:0]       hit_count;
    logic [COUNT_W-1:0]       fault_count;
  } result_t;

  // one row of the directed table
  typedef struct {
    op_e                     op;
    logic [PAGE_FIELD_W-1:0] pg;
    logic                    set_pol;
    policy_e                 pol;
    logic                    lit;
    result_t                 want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  prf_in_if  in_ch ();
  prf_out_if out_ch ();

  page_replacement_fifo_lru_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // frame set mirror
  logic [PAGE_FIELD_W-1:0] frm_page  [FRAMES];
  logic [FRAMES-1:0]       frm_valid = '0;
  logic [RANK_W-1:0]       frm_age   [FRAMES] = '{default: '0};
  logic [FRAME_W-1:0]      rot_ptr   = '0;
  logic [COUNT_W-1:0]      hit_tally   = '0;
  logic [COUNT_W-1:0]      fault_tally = '0;
  policy_e                 cur_policy  = POLICY_FIFO;

  result_t     pending_results [$];
  int unsigned err_count  = 0;
  int unsigned words_seen = 0;
  bit          idle_en    = 1'b0;
  int          stall_left = 0;

  // directed table: literal expectations only where obvious
  row_t dir_rows [25] = '{
    '{OP_ACCESS, 8'h00, 1'b0, POLICY_FIFO, 1'b1, '{1'b0, 2'd0, 1'b0, 8'h00, 16'd0, 16'd1}},
    '{OP_ACCESS, 8'hFF, 1'b0, POLICY_FIFO, 1'b1, '{1'b0, 2'd1, 1'b0, 8'h00, 16'd0, 16'd2}},
    '{OP_ACCESS, 8'h00, 1'b0, POLICY_FIFO, 1'b1, '{1'b1, 2'd0, 1'b0, 8'h00, 16'd1, 16'd2}},
    '{OP_ACCESS, 8'hFF, 1'b0, POLICY_FIFO, 1'b1, '{1'b1, 2'd1, 1'b0, 8'h00, 16'd2, 16'd2}},
    '{OP_ACCESS, 8'h55, 1'b0, POLICY_FIFO, 1'b0, '0},
    '{OP_ACCESS, 8'hAA, 1'b0, POLICY_FIFO, 1'b0, '0},
    '{OP_ACCESS, 8'h01, 1'b0, POLICY_FIFO, 1'b0, '0},
    '{OP_ACCESS, 8'h00, 1'b0, POLICY_FIFO, 1'b0, '0},
    '{OP_ACCESS, 8'h55, 1'b0, POLICY_FIFO, 1'b0, '0},
    '{OP_ACCESS, 8'hFE, 1'b0, POLICY_FIFO, 1'b0, '0},
    '{OP_CLEAR,  8'h00, 1'b0, POLICY_FIFO, 1'b1, '0},
    '{OP_CLEAR,  8'hFF, 1'b0, POLICY_FIFO, 1'b1, '0},
    '{OP_ACCESS, 8'h03, 1'b1, POLICY_LRU,  1'b1, '{1'b0, 2'd0, 1'b0, 8'h00, 16'd0, 16'd1}},
    '{OP_ACCESS, 8'h04, 1'b0, POLICY_LRU,  1'b0, '0},
    '{OP_ACCESS, 8'h05, 1'b0, POLICY_LRU,  1'b0, '0},
    '{OP_ACCESS, 8'h06, 1'b0, POLICY_LRU,  1'b0, '0},
    '{OP_ACCESS, 8'h03, 1'b0, POLICY_LRU,  1'b0, '0},
    '{OP_ACCESS, 8'h07, 1'b0, POLICY_LRU,  1'b0, '0},
    '{OP_ACCESS, 8'h05, 1'b0, POLICY_LRU,  1'b0, '0},
    '{OP_ACCESS, 8'h80, 1'b0, POLICY_LRU,  1'b0, '0},
    '{OP_ACCESS, 8'h7F, 1'b1, POLICY_FIFO, 1'b0, '0},
    '{OP_ACCESS, 8'h07, 1'b0, POLICY_FIFO, 1'b0, '0},
    '{OP_ACCESS, 8'h10, 1'b1, POLICY_LRU,  1'b0, '0},
    '{OP_CLEAR,  8'hFF, 1'b0, POLICY_LRU,  1'b1, '0},
    '{OP_ACCESS, 8'h00, 1'b0, POLICY_LRU,  1'b1, '{1'b0, 2'd0, 1'b0, 8'h00, 16'd0, 16'd1}}
  };

  // clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("[%0t] word %0d %s: got 0x%0h, want 0x%0h",
               $realtime, words_seen, what, got, want);
  endtask

  // replacement model: lookup, victim choice, recency ranks, saturating tallies
  task automatic replace_page(input op_e op, input logic [PAGE_FIELD_W-1:0] pg,
                              output result_t r);
    logic [FRAME_W-1:0]      tgt;
    logic                    found;
    logic                    empty_seen;
    logic                    was_valid;
    logic [RANK_W-1:0]       old_age;
    int                      f;
    r = '0;
    tgt = '0;
    found = 1'b0;
    if (op == OP_CLEAR) begin
      frm_valid = '0;
      for (f = 0; f < FRAMES; f++) frm_age[f] = '0;
      rot_ptr = '0;
      hit_tally = '0;
      fault_tally = '0;
      return;
    end
    // associative lookup, lowest frame wins
    for (f = 0; f < FRAMES; f++) begin
      if (!found && frm_valid[f] && frm_page[f] == pg) begin
        tgt = FRAME_W'(f);
        found = 1'b1;
      end
    end
    if (found) begin
      if (hit_tally != COUNT_MAX) hit_tally++;
    end else begin
      if (fault_tally != COUNT_MAX) fault_tally++;
      if (cur_policy == POLICY_FIFO) begin
        tgt = rot_ptr;
        rot_ptr = FRAME_W'((int'(tgt) + 1) % FRAMES);
      end else begin
        // empty frame first, else the oldest rank
        empty_seen = 1'b0;
        for (f = 0; f < FRAMES; f++) begin
          if (!empty_seen && !frm_valid[f]) begin
            tgt = FRAME_W'(f);
            empty_seen = 1'b1;
          end
        end
        if (!empty_seen) begin
          tgt = '0;
          for (f = 1; f < FRAMES; f++)
            if (frm_age[f] > frm_age[tgt]) tgt = FRAME_W'(f);
        end
      end
      if (frm_valid[tgt]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = frm_page[tgt];
      end
    end
    // make the target the most recent frame
    was_valid = frm_valid[tgt];
    old_age   = frm_age[tgt];
    for (f = 0; f < FRAMES; f++)
      if (f != tgt && frm_valid[f] && (!was_valid || frm_age[f] < old_age)) frm_age[f]++;
    frm_age[tgt]   = '0;
    frm_page[tgt]  = pg;
    frm_valid[tgt] = 1'b1;
    r.hit         = found;
    r.frame_index = FRAME_FIELD_W'(tgt);
    r.hit_count   = hit_tally;
    r.fault_count = fault_tally;
  endtask

  // send one access word, record what it should produce
  task automatic send_word(input op_e op, input logic [PAGE_FIELD_W-1:0] pg,
                           input logic lit, input result_t want);
    result_t predicted;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.page      <= pg;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    replace_page(op, pg, predicted);
    pending_results.push_back(lit ? want : predicted);
  endtask

  // apb transfer to the policy register, setup then access
  task automatic apb_xfer(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_POLICY, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // return to idle before the next transfer
    @(posedge clk_i);
  endtask

  // wait for the block to go idle, then write and read back the policy
  task automatic set_policy(input policy_e p);
    logic [APB_DATA_W-1:0] rd;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    apb_xfer(1'b1, {$urandom_range(0, 1) ? 31'($urandom()) : 31'd0, p}, rd);
    cur_policy = p;
    apb_xfer(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(p)) report_mismatch("policy readback", rd, APB_DATA_W'(p));
  endtask

  // result side backpressure in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 13);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.hit, out_ch.frame_index, out_ch.evicted_valid, out_ch.evicted_page,
              out_ch.hit_count, out_ch.fault_count};
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected", 32'(got.hit_count), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
        if (got.frame_index !== want.frame_index)
          report_mismatch("frame_index", 32'(got.frame_index), 32'(want.frame_index));
        if (got.evicted_valid !== want.evicted_valid)
          report_mismatch("evicted_valid", 32'(got.evicted_valid), 32'(want.evicted_valid));
        if (got.evicted_page !== want.evicted_page)
          report_mismatch("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
        if (got.hit_count !== want.hit_count)
          report_mismatch("hit_count", 32'(got.hit_count), 32'(want.hit_count));
        if (got.fault_count !== want.fault_count)
          report_mismatch("fault_count", 32'(got.fault_count), 32'(want.fault_count));
      end
      words_seen++;
    end
  end

  // main sequence
  initial begin
    logic [APB_DATA_W-1:0]   rd;
    logic [PAGE_FIELD_W-1:0] pool [8];
    int                      pool_n;
    int                      ph;
    int                      n;
    logic [PAGE_FIELD_W-1:0] pg;
    op_e                     op;
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_ACCESS;
    in_ch.page      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // policy comes out of reset as fifo
    apb_xfer(1'b0, '0, rd);
    if (rd !== APB_DATA_W'(POLICY_FIFO))
      report_mismatch("policy after reset", rd, APB_DATA_W'(POLICY_FIFO));

    // directed table
    idle_en = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_pol) set_policy(dir_rows[i].pol);
      send_word(dir_rows[i].op, dir_rows[i].pg, dir_rows[i].lit, dir_rows[i].want);
    end

    // random phases: a small page pool for hits, full range for the rest
    // the last phase runs with no idling on either side
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      set_policy((ph % 2) ? POLICY_LRU : POLICY_FIFO);
      idle_en = (ph < RAND_PHASES - 1);
      pool_n  = $urandom_range(3, 8);
      for (n = 0; n < pool_n; n++) pool[n] = PAGE_FIELD_W'($urandom_range(0, 255));
      for (n = 0; n < RAND_WORDS; n++) begin
        op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_ACCESS;
        pg = ($urandom_range(0, 3) == 0) ? PAGE_FIELD_W'($urandom_range(0, 255))
                                         : pool[$urandom_range(0, pool_n - 1)];
        send_word(op, pg, 1'b0, '0);
      end
    end

    // drain and settle
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0) begin
      $display("page_replacement_fifo_lru_top verification clean");
    end else begin
      $display("page_replacement_fifo_lru_top verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("page_replacement_fifo_lru_top verification failed");
    $finish;
  end

endmodule

### page_replacement_fifo_lru_top.f
+incdir+rtl/core
rtl/core/prf_pkg.sv
rtl/core/prf_if.sv
rtl/core/prf_ram.sv
rtl/core/page_replacement_fifo_lru_top.sv
bench/tb_top.sv
